// File: design/b64c_pkg.sv
`timescale 1ns / 1ps

package b64c_pkg;

    localparam int unsigned MaxWords = 4;

    localparam logic [7:0] CharPad   = 8'h3D;  // '='
    localparam logic [7:0] CharPlus  = 8'h2B;  // '+'
    localparam logic [7:0] CharSlash = 8'h2F;  // '/'

    // One finished group: up to four output words, first word in slot 0
    typedef struct packed {
        logic                emit;
        logic [2:0]          count;
        logic [3:0][7:0]     data;
        logic [3:0]          last;
        logic [3:0]          bad;
    } t_bundle;

    // Six-bit value to alphabet character
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'(v) + 8'h41;
        end else if (v < 6'd52) begin
            c = 8'(v) - 8'd26 + 8'h61;
        end else if (v < 6'd62) begin
            c = 8'(v) - 8'd52 + 8'h30;
        end else if (v == 6'd62) begin
            c = CharPlus;
        end else begin
            c = CharSlash;
        end
        return c;
    endfunction

    // Character to {valid, six-bit value}
    function automatic logic [6:0] dec_val(input logic [7:0] c);
        logic [6:0] r;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b1, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end else if (c == CharPlus) begin
            r = {1'b1, 6'd62};
        end else if (c == CharSlash) begin
            r = {1'b1, 6'd63};
        end else begin
            r = 7'd0;
        end
        return r;
    endfunction

endpackage

// File: design/b64c_group.sv
`timescale 1ns / 1ps

// Group collector: holds the partial group and forms the output words
// when a group completes or the message ends.
module b64c_group (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clear,
    input  logic                 i_mode,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output b64c_pkg::t_bundle    o_bundle
);

    logic [23:0] r_bits, n_bits;
    logic [1:0]  r_count, n_count;
    logic [1:0]  r_pad, n_pad;
    logic        r_err, n_err;

    logic [23:0] sh_bits;
    logic [23:0] al_bits;
    logic [2:0]  num;
    logic [6:0]  dv;
    logic [5:0]  v;
    logic [2:0]  pads;
    logic [2:0]  cnt_out;
    logic        done;
    logic [1:0]  pad_nx;
    logic        err_nx;
    logic        grp_bad;
    b64c_pkg::t_bundle bnd;

    always_comb begin
        n_bits  = r_bits;
        n_count = r_count;
        n_pad   = r_pad;
        n_err   = r_err;
        pad_nx  = r_pad;
        err_nx  = r_err;
        grp_bad = 1'b0;
        sh_bits = '0;
        al_bits = '0;
        v       = '0;
        pads    = '0;
        cnt_out = '0;
        num     = 3'(r_count) + 3'd1;
        dv      = b64c_pkg::dec_val(i_byte);
        bnd     = '0;
        done    = 1'b0;

        if (!i_mode) begin
            // encode: three bytes in, four characters out
            sh_bits = {r_bits[15:0], i_byte};
            done    = (num == 3'd3) || i_last;
            case (num)
                3'd1:    al_bits = {sh_bits[7:0], 16'd0};
                3'd2:    al_bits = {sh_bits[15:0], 8'd0};
                default: al_bits = sh_bits;
            endcase
            for (int k = 0; k < 4; k++) begin
                if (3'(k) <= num) begin
                    bnd.data[k] = b64c_pkg::enc_char(al_bits[23 - 6 * k -: 6]);
                end else begin
                    bnd.data[k] = b64c_pkg::CharPad;
                end
            end
            bnd.last  = {i_last, 3'b000};
            bnd.bad   = '0;
            bnd.count = 3'(b64c_pkg::MaxWords);
        end else begin
            // decode: classify the character against pad state
            if (dv[6] && r_pad == 2'd0) begin
                v = dv[5:0];
            end else if (dv[6]) begin
                err_nx = 1'b1;
                if (r_pad < 2'd2) pad_nx = r_pad + 2'd1;
            end else if (i_byte == b64c_pkg::CharPad && r_count >= 2'd2) begin
                if (r_pad < 2'd2) pad_nx = r_pad + 2'd1;
            end else begin
                err_nx = 1'b1;
            end
            grp_bad = err_nx;
            sh_bits = {r_bits[17:0], v};
            done    = (num == 3'd4) || i_last;
            // missing places count as pads
            case (num)
                3'd1: begin
                    al_bits = {sh_bits[5:0], 18'd0};
                    pads    = 3'd2;
                    grp_bad = 1'b1;
                end
                3'd2: begin
                    al_bits = {sh_bits[11:0], 12'd0};
                    pads    = 3'd2;
                end
                3'd3: begin
                    al_bits = {sh_bits[17:0], 6'd0};
                    pads    = (pad_nx == 2'd0) ? 3'd1 : 3'd2;
                end
                default: begin
                    al_bits = sh_bits;
                    pads    = 3'(pad_nx);
                end
            endcase
            cnt_out = 3'd3 - pads;
            for (int k = 0; k < 3; k++) begin
                bnd.data[k] = al_bits[23 - 8 * k -: 8];
                bnd.last[k] = i_last && (3'(k) + 3'd1 == cnt_out);
                bnd.bad[k]  = grp_bad;
            end
            bnd.count = cnt_out;
        end

        bnd.emit = i_accept && done;

        if (i_accept) begin
            if (done) begin
                n_bits  = '0;
                n_count = '0;
                n_pad   = '0;
                n_err   = 1'b0;
            end else begin
                n_bits  = sh_bits;
                n_count = num[1:0];
                n_pad   = pad_nx;
                n_err   = err_nx;
            end
        end
        if (i_clear) begin
            n_bits  = '0;
            n_count = '0;
            n_pad   = '0;
            n_err   = 1'b0;
        end
    end

    assign o_bundle = bnd;

    // group state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits  <= '0;
            r_count <= '0;
            r_pad   <= '0;
            r_err   <= 1'b0;
        end else begin
            r_bits  <= n_bits;
            r_count <= n_count;
            r_pad   <= n_pad;
            r_err   <= n_err;
        end
    end

endmodule

// File: design/base64_codec_top.sv
`timescale 1ns / 1ps

// Channel  | Dir | tdata       | tlast    | tuser
// s_axis   | in  | in_byte     | in_last  | -
// m_axis   | out | out_byte    | out_last | bad_char
// cfg      | in  | decode_mode (write enable + data, no readback)
//
// One item is taken per cycle while the output buffer is free; a finished
// group loads up to four words into the buffer, which drains one word per
// cycle while m_axis is ready. A full encode group takes three bytes and a
// full decode group four characters; the single output port limits the
// group rate. The last buffered word and the next input can pass in the
// same cycle. Reset is synchronous, active low, and clears the group and
// the buffer. Stalls on m_axis hold the buffer and block input.
module base64_codec_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,      // decode_mode
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,     // [7:0] in_byte
    input  logic       s_axis_tlast,     // in_last
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,     // [7:0] out_byte
    output logic       m_axis_tlast,     // out_last
    output logic       m_axis_tuser      // [0] bad_char
);

    logic              r_mode;
    logic [2:0]        r_cnt;
    logic [3:0][7:0]   r_data;
    logic [3:0]        r_last;
    logic [3:0]        r_bad;
    logic              s_word;
    logic              m_word;
    b64c_pkg::t_bundle bnd;

    assign m_word        = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_cnt == 3'd0) || (r_cnt == 3'd1 && m_axis_tready);
    assign s_word        = s_axis_tvalid && s_axis_tready;

    b64c_group u_group (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (i_cfg_we),
        .i_mode   (r_mode),
        .i_accept (s_word),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_bundle (bnd)
    );

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // output buffer: load a finished group, shift out one word per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (bnd.emit) begin
            r_cnt <= bnd.count;
        end else if (m_word) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (bnd.emit) begin
            r_data <= bnd.data;
            r_last <= bnd.last;
            r_bad  <= bnd.bad;
        end else if (m_word) begin
            r_data <= {8'd0, r_data[3:1]};
            r_last <= {1'b0, r_last[3:1]};
            r_bad  <= {1'b0, r_bad[3:1]};
        end
    end

    assign m_axis_tvalid = (r_cnt != 3'd0);
    assign m_axis_tdata  = r_data[0];
    assign m_axis_tlast  = r_last[0];
    assign m_axis_tuser  = r_bad[0];

    // buffer never holds more than one group
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("output buffer count out of range");

    // input only taken when buffer is draining its final word or empty
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_word |-> (r_cnt == 3'd0 || (r_cnt == 3'd1 && m_word)))
        else $error("input accepted over a busy buffer");

    // encoder never flags a bad character
    a_enc_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !r_mode) |-> !m_axis_tuser)
        else $error("bad_char set in encode mode");

    // a drained buffer with no new group goes empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 3'd1 && m_word && !bnd.emit) |=> (r_cnt == 3'd0))
        else $error("buffer failed to drain");

endmodule
